// ===== hw/rtl/ppts_pkg.sv =====
// Package for the periodic priority task scheduler.
// Holds the word types, the table entry layout and the item and status codes.
// No dependencies.
package ppts_pkg;

  localparam int MAX_TASKS_DEF = 8;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 8;
  localparam int PERIOD_W = 16;
  localparam int PRIO_W   = 8;
  localparam int SLOTO_W  = 3;
  localparam int STATUS_W = 2;
  localparam int TSTATE_W = 2;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_CREATE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // Per-slot task status.
  localparam logic [TSTATE_W-1:0] TS_READY   = 2'd0;
  localparam logic [TSTATE_W-1:0] TS_WAITING = 2'd1;
  localparam logic [TSTATE_W-1:0] TS_DELETED = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     task_id;
    logic [PERIOD_W-1:0] period;
    logic [PRIO_W-1:0]   priority_req;
  } in_word_t;

  typedef struct packed {
    logic                dispatch_valid;
    logic [SLOTO_W-1:0]  dispatched_slot;
    logic [ID_W-1:0]     dispatched_id;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [TSTATE_W-1:0] tstate;
    logic [ID_W-1:0]     ident;
    logic [PRIO_W-1:0]   prio;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] countdown;
  } entry_t;

endpackage

// ===== hw/rtl/periodic_priority_task_scheduler_unit.sv =====
// Top level of the periodic priority task scheduler.
// Keeps the task table in one synchronous memory and walks it for non-create items.
// Depends on ppts_pkg.
//
//  channel  ports                     handshake
//  input    start, busy, in_word      taken when start is high and busy is low
//  result   out_valid, out_word       one word per item, valid for one cycle
//
// A create item's result word is shown in the cycle right after the edge that takes it.
// Delete, tick and dispatch items walk the created slots through the single read
// port, one slot per cycle, a delete stopping at its first match; busy stays high
// during the walk and the result word is shown in the cycle after, when a new word
// may already be taken.
// After reset the table is empty and the block is idle; results cannot be held off.
module periodic_priority_task_scheduler_unit #(
  parameter int MAX_TASKS = ppts_pkg::MAX_TASKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ppts_pkg::in_word_t  in_word,
  output logic                out_valid,
  output ppts_pkg::out_word_t out_word
);

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } fsm_t;

  fsm_t                             state_r;
  logic [ppts_pkg::KIND_W-1:0]      kind_r;
  logic [ppts_pkg::ID_W-1:0]        id_r;
  logic [CNT_W-1:0]                 count_r;
  logic [CNT_W-1:0]                 idx_r;
  logic                             issue_r;
  logic [SLOT_W-1:0]                eidx_r;
  logic                             any_r;
  logic                             found_r;
  logic [SLOT_W-1:0]                best_r;
  ppts_pkg::entry_t                 best_ent_r;
  ppts_pkg::entry_t                 rdata_r;
  logic                             out_valid_r;
  ppts_pkg::out_word_t              out_word_r;

  ppts_pkg::entry_t                 mem [MAX_TASKS];

  logic                             accept;
  logic                             table_full;
  logic                             del_hit;
  logic                             take_best;
  logic                             next_issue;
  logic                             rd_en;
  logic [SLOT_W-1:0]                rd_addr;
  logic                             mem_we;
  logic [SLOT_W-1:0]                mem_waddr;
  ppts_pkg::entry_t                 mem_wdata;
  ppts_pkg::entry_t                 ent_tick;
  logic [ppts_pkg::PERIOD_W-1:0]    cd_dec;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && (state_r == S_IDLE);
  assign table_full = (count_r >= CNT_W'(MAX_TASKS));

  // Evaluation stage: rdata_r holds slot eidx_r when issue_r is set.
  assign del_hit   = (state_r == S_WALK) && issue_r && (kind_r == ppts_pkg::KIND_DELETE) &&
                     (rdata_r.ident == id_r);
  assign take_best = (state_r == S_WALK) && issue_r && (kind_r == ppts_pkg::KIND_DISPATCH) &&
                     (rdata_r.tstate == ppts_pkg::TS_READY) &&
                     (!any_r || (rdata_r.prio >= best_ent_r.prio));

  assign next_issue = (idx_r < count_r) && !del_hit;
  assign rd_en      = (state_r == S_WALK) && next_issue;
  assign rd_addr    = idx_r[SLOT_W-1:0];

  assign cd_dec = rdata_r.countdown - ppts_pkg::PERIOD_W'(1);

  always_comb begin
    ent_tick = rdata_r;
    if (cd_dec == '0) begin
      ent_tick.tstate    = ppts_pkg::TS_READY;
      ent_tick.countdown = rdata_r.period;
    end else begin
      ent_tick.countdown = cd_dec;
    end
  end

  // Single write port: create, delete mark, tick update, dispatch mark.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = eidx_r;
    mem_wdata = rdata_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_word.kind == ppts_pkg::KIND_CREATE) && !table_full) begin
          mem_we              = 1'b1;
          mem_waddr           = count_r[SLOT_W-1:0];
          mem_wdata.tstate    = ppts_pkg::TS_READY;
          mem_wdata.ident     = in_word.task_id;
          mem_wdata.prio      = in_word.priority_req;
          mem_wdata.period    = in_word.period;
          mem_wdata.countdown = in_word.period;
        end
      end
      S_WALK: begin
        if (del_hit) begin
          mem_we           = 1'b1;
          mem_wdata.tstate = ppts_pkg::TS_DELETED;
        end else if (issue_r && (kind_r == ppts_pkg::KIND_TICK) &&
                     (rdata_r.tstate == ppts_pkg::TS_WAITING)) begin
          mem_we    = 1'b1;
          mem_wdata = ent_tick;
        end
      end
      S_FINISH: begin
        if ((kind_r == ppts_pkg::KIND_DISPATCH) && any_r) begin
          mem_we           = 1'b1;
          mem_waddr        = best_r;
          mem_wdata        = best_ent_r;
          mem_wdata.tstate = ppts_pkg::TS_WAITING;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Reads and writes never touch the same slot in one cycle: the tick write
  // trails the read by one slot and the dispatch write comes after the walk.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      issue_r     <= 1'b0;
      any_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r  <= in_word.kind;
            id_r    <= in_word.task_id;
            idx_r   <= '0;
            issue_r <= 1'b0;
            any_r   <= 1'b0;
            found_r <= 1'b0;
            if (in_word.kind == ppts_pkg::KIND_CREATE) begin
              out_valid_r                <= 1'b1;
              out_word_r.dispatch_valid  <= 1'b0;
              out_word_r.dispatched_slot <= '0;
              out_word_r.dispatched_id   <= '0;
              if (table_full) begin
                out_word_r.status <= ppts_pkg::STATUS_FULL;
              end else begin
                out_word_r.status <= ppts_pkg::STATUS_OK;
                count_r           <= count_r + CNT_W'(1);
              end
            end else begin
              state_r <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (take_best) begin
            any_r      <= 1'b1;
            best_r     <= eidx_r;
            best_ent_r <= rdata_r;
          end
          if (del_hit) begin
            found_r <= 1'b1;
          end
          issue_r <= next_issue;
          if (next_issue) begin
            eidx_r <= idx_r[SLOT_W-1:0];
            idx_r  <= idx_r + CNT_W'(1);
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
          if ((kind_r == ppts_pkg::KIND_DISPATCH) && any_r) begin
            out_word_r.dispatch_valid  <= 1'b1;
            out_word_r.dispatched_slot <= ppts_pkg::SLOTO_W'(best_r);
            out_word_r.dispatched_id   <= best_ent_r.ident;
          end else begin
            out_word_r.dispatch_valid  <= 1'b0;
            out_word_r.dispatched_slot <= '0;
            out_word_r.dispatched_id   <= '0;
          end
          if ((kind_r == ppts_pkg::KIND_DELETE) && !found_r) begin
            out_word_r.status <= ppts_pkg::STATUS_NOT_FOUND;
          end else begin
            out_word_r.status <= ppts_pkg::STATUS_OK;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== hw/rtl/ppts_checker.sv =====
// Port-level checker for the periodic priority task scheduler, with its bind.
// Watches the command and result ports only.
// Depends on ppts_pkg and periodic_priority_task_scheduler_unit.
module ppts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input ppts_pkg::in_word_t  in_word,
  input logic                out_valid,
  input ppts_pkg::out_word_t out_word
);

  // A create word's result follows in the next cycle and never reports a dispatch.
  a_create_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.kind == ppts_pkg::KIND_CREATE))
      |=> (out_valid && !out_word.dispatch_valid))
    else $error("create word did not complete in one cycle");

  // A result word only follows an accepted word or a busy cycle.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start))) else $error("result word without a command");

  // A dispatch that found a task always reports status ok.
  a_dispatch_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.dispatch_valid) |-> (out_word.status == ppts_pkg::STATUS_OK))
    else $error("dispatch result with error status");

  // Without a dispatch the slot and id fields read zero.
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.dispatch_valid)
      |-> ((out_word.dispatched_slot == '0) && (out_word.dispatched_id == '0)))
    else $error("slot or id set without a dispatch");

endmodule

bind periodic_priority_task_scheduler_unit ppts_checker u_ppts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for periodic_priority_task_scheduler_unit.
// Drives command words through start/busy and checks every result word against its own
// scheduler predictor or a directed expected word. Depends on ppts_pkg and the RTL.
module testbench;

  localparam int SLOTS        = ppts_pkg::MAX_TASKS_DEF;
  localparam int RANDOM_WORDS = 1200;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    ppts_pkg::in_word_t  cmd;
    bit                  typed;
    ppts_pkg::out_word_t res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  ppts_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  ppts_pkg::out_word_t out_word;

  // Scheduler state as the testbench sees it.
  int                            sched_count;
  logic [ppts_pkg::TSTATE_W-1:0] slot_state[SLOTS];
  logic [ppts_pkg::ID_W-1:0]     slot_ident[SLOTS];
  logic [ppts_pkg::PRIO_W-1:0]   slot_prio[SLOTS];
  logic [ppts_pkg::PERIOD_W-1:0] slot_period[SLOTS];
  logic [ppts_pkg::PERIOD_W-1:0] slot_countdown[SLOTS];

  ppts_pkg::out_word_t pending_results[$];
  dir_row_t            dir_rows[$];
  int                  mismatch_count = 0;
  int                  cycle_count = 0;

  periodic_priority_task_scheduler_unit #(
    .MAX_TASKS(SLOTS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("periodic_priority_task_scheduler_unit test failed");
      $finish;
    end
  end

  function automatic ppts_pkg::in_word_t mk_cmd(logic [ppts_pkg::KIND_W-1:0] kind,
                                                logic [ppts_pkg::ID_W-1:0] id,
                                                logic [ppts_pkg::PERIOD_W-1:0] per,
                                                logic [ppts_pkg::PRIO_W-1:0] prio);
    ppts_pkg::in_word_t w;
    w.kind         = kind;
    w.task_id      = id;
    w.period       = per;
    w.priority_req = prio;
    return w;
  endfunction

  function automatic ppts_pkg::out_word_t mk_res(logic v,
                                                 logic [ppts_pkg::SLOTO_W-1:0] slot,
                                                 logic [ppts_pkg::ID_W-1:0] id,
                                                 logic [ppts_pkg::STATUS_W-1:0] st);
    ppts_pkg::out_word_t r;
    r.dispatch_valid  = v;
    r.dispatched_slot = slot;
    r.dispatched_id   = id;
    r.status          = st;
    return r;
  endfunction

  // Applies one command to the scheduler state and returns the result word.
  function automatic ppts_pkg::out_word_t schedule_outcome(ppts_pkg::in_word_t w);
    ppts_pkg::out_word_t r;
    int                  best;
    bit                  any;
    bit                  found;
    r = mk_res(1'b0, '0, '0, ppts_pkg::STATUS_OK);
    best = 0;
    any = 1'b0;
    found = 1'b0;
    case (w.kind)
      ppts_pkg::KIND_CREATE: begin
        if (sched_count >= SLOTS) begin
          r.status = ppts_pkg::STATUS_FULL;
        end else begin
          slot_ident[sched_count]     = w.task_id;
          slot_prio[sched_count]      = w.priority_req;
          slot_period[sched_count]    = w.period;
          slot_countdown[sched_count] = w.period;
          slot_state[sched_count]     = ppts_pkg::TS_READY;
          sched_count++;
        end
      end
      ppts_pkg::KIND_DELETE: begin
        // The lowest matching slot is hit, even one that is already deleted.
        for (int i = 0; i < sched_count && !found; i++) begin
          if (slot_ident[i] == w.task_id) begin
            slot_state[i] = ppts_pkg::TS_DELETED;
            found = 1'b1;
          end
        end
        if (!found) r.status = ppts_pkg::STATUS_NOT_FOUND;
      end
      ppts_pkg::KIND_TICK: begin
        for (int i = 0; i < sched_count; i++) begin
          if (slot_state[i] == ppts_pkg::TS_WAITING) begin
            slot_countdown[i] = slot_countdown[i] - 1'b1;
            if (slot_countdown[i] == '0) begin
              slot_state[i]     = ppts_pkg::TS_READY;
              slot_countdown[i] = slot_period[i];
            end
          end
        end
      end
      default: begin
        // Ties go to the higher slot, hence the >= in the search.
        for (int i = 0; i < sched_count; i++) begin
          if (slot_state[i] == ppts_pkg::TS_READY &&
              (!any || slot_prio[i] >= slot_prio[best])) begin
            best = i;
            any = 1'b1;
          end
        end
        if (any) begin
          slot_state[best]  = ppts_pkg::TS_WAITING;
          r.dispatch_valid  = 1'b1;
          r.dispatched_slot = best[ppts_pkg::SLOTO_W-1:0];
          r.dispatched_id   = slot_ident[best];
        end
      end
    endcase
    return r;
  endfunction

  function automatic ppts_pkg::in_word_t random_command();
    ppts_pkg::in_word_t w;
    int unsigned        pick;
    w.task_id      = ppts_pkg::ID_W'($urandom);
    w.period       = ppts_pkg::PERIOD_W'($urandom);
    w.priority_req = ppts_pkg::PRIO_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      w.kind = ppts_pkg::KIND_CREATE;
      if ($urandom_range(0, 3) != 0) w.period = ppts_pkg::PERIOD_W'($urandom_range(1, 8));
    end else if (pick < 11) begin
      w.kind = ppts_pkg::KIND_DELETE;
      // Mostly hit the duplicate id so that live tasks are seldom removed.
      if (sched_count > 0 && $urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 4) != 0) w.task_id = 8'h5A;
        else w.task_id = slot_ident[$urandom_range(0, sched_count - 1)];
      end
    end else if (pick < 55) begin
      w.kind = ppts_pkg::KIND_TICK;
    end else begin
      w.kind = ppts_pkg::KIND_DISPATCH;
    end
    return w;
  endfunction

  task automatic add_row(ppts_pkg::in_word_t cmd, bit typed, ppts_pkg::out_word_t res);
    dir_row_t row;
    row.cmd   = cmd;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  // Presents one word and returns at the edge that takes it.
  task automatic issue_word(ppts_pkg::in_word_t w, bit typed, ppts_pkg::out_word_t typed_res);
    ppts_pkg::out_word_t predicted;
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = schedule_outcome(w);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic pause_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    ppts_pkg::out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %p", out_word);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_word.dispatch_valid !== want.dispatch_valid) begin
          $error("dispatch_valid: expected %0d, got %0d",
                 want.dispatch_valid, out_word.dispatch_valid);
          mismatch_count++;
        end
        if (out_word.dispatched_slot !== want.dispatched_slot) begin
          $error("dispatched_slot: expected %0d, got %0d",
                 want.dispatched_slot, out_word.dispatched_slot);
          mismatch_count++;
        end
        if (out_word.dispatched_id !== want.dispatched_id) begin
          $error("dispatched_id: expected %0h, got %0h",
                 want.dispatched_id, out_word.dispatched_id);
          mismatch_count++;
        end
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    ppts_pkg::out_word_t ok;
    int                  burst;
    int                  sent;
    ok = mk_res(1'b0, '0, '0, ppts_pkg::STATUS_OK);
    sched_count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_state[i]     = ppts_pkg::TS_READY;
      slot_ident[i]     = '0;
      slot_prio[i]      = '0;
      slot_period[i]    = '0;
      slot_countdown[i] = '0;
    end

    // Empty table, then a tie on top priority and a period of zero.
    add_row(mk_cmd(ppts_pkg::KIND_DISPATCH, 8'h00, 16'h0000, 8'h00), 1'b1, ok);
    add_row(mk_cmd(ppts_pkg::KIND_TICK, 8'h00, 16'h0000, 8'h00), 1'b1, ok);
    add_row(mk_cmd(ppts_pkg::KIND_DELETE, 8'h00, 16'h0000, 8'h00), 1'b1,
            mk_res(1'b0, '0, '0, ppts_pkg::STATUS_NOT_FOUND));
    add_row(mk_cmd(ppts_pkg::KIND_CREATE, 8'hFF, 16'hFFFF, 8'hFF), 1'b1, ok);
    add_row(mk_cmd(ppts_pkg::KIND_CREATE, 8'h00, 16'h0001, 8'h00), 1'b1, ok);
    add_row(mk_cmd(ppts_pkg::KIND_CREATE, 8'h5A, 16'h0000, 8'hFF), 1'b1, ok);
    add_row(mk_cmd(ppts_pkg::KIND_DISPATCH, 8'h00, 16'h0000, 8'h00), 1'b1,
            mk_res(1'b1, 3'd2, 8'h5A, ppts_pkg::STATUS_OK));
    add_row(mk_cmd(ppts_pkg::KIND_DISPATCH, 8'h00, 16'h0000, 8'h00), 1'b1,
            mk_res(1'b1, 3'd0, 8'hFF, ppts_pkg::STATUS_OK));
    add_row(mk_cmd(ppts_pkg::KIND_DISPATCH, 8'h00, 16'h0000, 8'h00), 1'b1,
            mk_res(1'b1, 3'd1, 8'h00, ppts_pkg::STATUS_OK));
    add_row(mk_cmd(ppts_pkg::KIND_DISPATCH, 8'h00, 16'h0000, 8'h00), 1'b1, ok);
    add_row(mk_cmd(ppts_pkg::KIND_TICK, 8'h00, 16'h0000, 8'h00), 1'b0, ok);
    add_row(mk_cmd(ppts_pkg::KIND_DISPATCH, 8'h00, 16'h0000, 8'h00), 1'b0, ok);
    // A second task with the same id; deletes keep hitting the lower slot.
    add_row(mk_cmd(ppts_pkg::KIND_CREATE, 8'h5A, 16'h0002, 8'h80), 1'b1, ok);
    add_row(mk_cmd(ppts_pkg::KIND_DELETE, 8'h5A, 16'h0000, 8'h00), 1'b0, ok);
    add_row(mk_cmd(ppts_pkg::KIND_DELETE, 8'h5A, 16'h0000, 8'h00), 1'b0, ok);
    add_row(mk_cmd(ppts_pkg::KIND_CREATE, 8'h11, 16'h0003, 8'h80), 1'b1, ok);
    add_row(mk_cmd(ppts_pkg::KIND_CREATE, 8'hA5, 16'h0005, 8'h01), 1'b1, ok);
    add_row(mk_cmd(ppts_pkg::KIND_CREATE, 8'h3C, 16'h0007, 8'hC3), 1'b1, ok);
    add_row(mk_cmd(ppts_pkg::KIND_CREATE, 8'hC3, 16'h0100, 8'h3C), 1'b1, ok);
    add_row(mk_cmd(ppts_pkg::KIND_CREATE, 8'h77, 16'h0004, 8'h10), 1'b1,
            mk_res(1'b0, '0, '0, ppts_pkg::STATUS_FULL));
    add_row(mk_cmd(ppts_pkg::KIND_DELETE, 8'h99, 16'h0000, 8'h00), 1'b1,
            mk_res(1'b0, '0, '0, ppts_pkg::STATUS_NOT_FOUND));
    add_row(mk_cmd(ppts_pkg::KIND_DISPATCH, 8'h00, 16'h0000, 8'h00), 1'b0, ok);
    add_row(mk_cmd(ppts_pkg::KIND_DISPATCH, 8'h00, 16'h0000, 8'h00), 1'b0, ok);
    add_row(mk_cmd(ppts_pkg::KIND_TICK, 8'hFF, 16'hFFFF, 8'hFF), 1'b0, ok);
    add_row(mk_cmd(ppts_pkg::KIND_DISPATCH, 8'hFF, 16'hFFFF, 8'hFF), 1'b0, ok);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      issue_word(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
      if ($urandom_range(0, 3) == 0) pause_cycles($urandom_range(1, 6));
    end
    drain_results();

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
        issue_word(random_command(), 1'b0, ok);
        sent++;
        if (sent % 400 == 0) drain_results();
      end
      // Mostly short gaps, now and then none or a long one.
      case ($urandom_range(0, 5))
        0: pause_cycles(0);
        1: pause_cycles($urandom_range(10, 30));
        default: pause_cycles($urandom_range(1, 12));
      endcase
    end

    drain_results();
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("periodic_priority_task_scheduler_unit test passed");
    end else begin
      $display("periodic_priority_task_scheduler_unit test failed");
    end
    $finish;
  end

endmodule
